/* rtl/c3cf_pkg.sv */
// Shared types and constants of the 3x3 convolution filter.
`timescale 1ns / 1ps

package c3cf_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int PIX_W       = 3 * SAMPLE_W;
	localparam int COEF_W      = 16;
	localparam int KROW_W      = 3 * COEF_W;
	localparam int PROD_W      = SAMPLE_W + 1 + COEF_W;
	localparam int BIAS_W      = 10;
	localparam int DIM_CFG_W   = 11;
	localparam int CFG_DATA_W  = KROW_W;
	localparam int CFG_INDEX_W = 3;
	localparam int SAMPLE_MAX  = 255;
	localparam int DIM_RESET   = 256;
	localparam logic [KROW_W-1:0] KERNEL_MID_RESET = 48'h0000_1000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KERNEL_TOP,
		REG_KERNEL_MID,
		REG_KERNEL_BOTTOM,
		REG_BIAS,
		REG_COLOR_MODE,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_t;

	typedef logic [PIX_W-1:0]  pixel_t;   // blue 23:16, green 15:8, red 7:0
	typedef logic [KROW_W-1:0] krow_t;
	typedef pixel_t [2:0]      win_row_t;
	typedef win_row_t [2:0]    window_t;  // [row top..bottom][column left..right]

	typedef struct packed {
		logic pad_item;
		logic [SAMPLE_W-1:0] sample_r;
		logic [SAMPLE_W-1:0] sample_g;
		logic [SAMPLE_W-1:0] sample_b;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_r;
		logic [SAMPLE_W-1:0] out_g;
		logic [SAMPLE_W-1:0] out_b;
		logic frame_last;
	} out_item_t;

	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bottom;
	} edge_mask_t;

	typedef struct packed {
		logic rgb;
		logic last;
	} pix_ctrl_t;

endpackage

/* rtl/c3cf_line_buf.sv */
// Two-line delay store holding the samples one and two rows back.
`timescale 1ns / 1ps

module c3cf_line_buf #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           restart,
	input  c3cf_pkg::pixel_t               sample,
	input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
	output c3cf_pkg::pixel_t               tap_mid,
	output c3cf_pkg::pixel_t               tap_top
);
	import c3cf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	typedef struct packed {
		pixel_t older;
		pixel_t newer;
	} line_entry_t;

	line_entry_t mem [MAX_WIDTH];
	line_entry_t rd_q;
	line_entry_t wr_entry;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ptr_next;
	logic [AW-1:0] rd_addr;
	logic [WW-1:0] w_m1;

	assign w_m1     = width - 1'b1;
	assign ptr_next = (restart || ptr_q == w_m1[AW-1:0]) ? '0 : ptr_q + 1'b1;
	// read ahead at the address of the next transaction
	assign rd_addr  = restart ? '0 : (accept ? ptr_next : ptr_q);
	assign wr_entry = '{older: rd_q.newer, newer: sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (accept || restart) begin
			ptr_q <= ptr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[ptr_q] <= wr_entry;
		end
		// one-pixel rows read back the entry being written
		if (accept && rd_addr == ptr_q) begin
			rd_q <= wr_entry;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign tap_mid = rd_q.newer;
	assign tap_top = rd_q.older;

endmodule

/* rtl/c3cf_product_stage.sv */
// Product stage: 27 masked sample by coefficient products, truncated toward zero.
`timescale 1ns / 1ps

module c3cf_product_stage #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  c3cf_pkg::window_t     win,
	input  c3cf_pkg::edge_mask_t  mask,
	input  c3cf_pkg::pix_ctrl_t   ctrl,
	input  c3cf_pkg::krow_t [2:0] kernel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0][8:0][c3cf_pkg::PROD_W-COEF_FRAC_BITS-1:0] prod,
	output c3cf_pkg::pix_ctrl_t   ctrl_out
);
	import c3cf_pkg::*;

	localparam int TW  = PROD_W - COEF_FRAC_BITS;
	localparam int RND = (1 << COEF_FRAC_BITS) - 1;

	logic v_q;
	logic [2:0][8:0][TW-1:0] prod_s2;
	pix_ctrl_t ctrl_s2;
	logic [2:0][8:0][TW-1:0] prod_d;
	logic [2:0] row_en;
	logic [2:0] col_en;

	function automatic logic [TW-1:0] trunc_zero(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] adj;
		adj = p + (p[PROD_W-1] ? PROD_W'(RND) : '0);
		return adj[PROD_W-1:COEF_FRAC_BITS];
	endfunction

	assign row_en = {mask.bottom, 1'b1, mask.top};
	assign col_en = {mask.right, 1'b1, mask.left};

	always_comb begin
		logic [SAMPLE_W-1:0] s;
		logic signed [COEF_W-1:0] coef;
		logic signed [PROD_W-1:0] p;
		prod_d = '0;
		for (int ch = 0; ch < 3; ch++) begin
			for (int ky = 0; ky < 3; ky++) begin
				for (int kx = 0; kx < 3; kx++) begin
					// taps outside the image count as zero samples
					s = (row_en[ky] && col_en[kx]) ? win[ky][kx][SAMPLE_W*ch +: SAMPLE_W] : '0;
					coef = kernel[ky][COEF_W*kx +: COEF_W];
					p = $signed({1'b0, s}) * coef;
					prod_d[ch][3*ky+kx] = trunc_zero(p);
				end
			end
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s2 <= prod_d;
			ctrl_s2 <= ctrl;
		end
	end

	assign out_valid = v_q;
	assign prod      = prod_s2;
	assign ctrl_out  = ctrl_s2;

endmodule

/* rtl/c3cf_sum_stage.sv */
// Sum stage: add the nine products and the bias, clamp each channel, hold the result.
`timescale 1ns / 1ps

module c3cf_sum_stage #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0][8:0][c3cf_pkg::PROD_W-COEF_FRAC_BITS-1:0] prod,
	input  c3cf_pkg::pix_ctrl_t                 ctrl,
	input  logic signed [c3cf_pkg::BIAS_W-1:0]  bias,
	output logic                                out_valid,
	input  logic                                out_stall,
	output c3cf_pkg::out_item_t                 result
);
	import c3cf_pkg::*;

	localparam int TW = PROD_W - COEF_FRAC_BITS;
	localparam int SW = TW + 5;
	localparam logic signed [SW-1:0] CLAMP_HI = SW'(SAMPLE_MAX);

	logic v_q;
	out_item_t res_q;
	out_item_t res_d;
	logic signed [2:0][SW-1:0] acc;

	function automatic logic [SAMPLE_W-1:0] clamp_byte(input logic signed [SW-1:0] v);
		if (v < 0) begin
			return '0;
		end else if (v > CLAMP_HI) begin
			return SAMPLE_W'(SAMPLE_MAX);
		end
		return v[SAMPLE_W-1:0];
	endfunction

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = SW'(bias);
			for (int i = 0; i < 9; i++) begin
				acc[ch] = acc[ch] + SW'($signed(prod[ch][i]));
			end
		end
		res_d.out_r      = clamp_byte(acc[0]);
		res_d.out_g      = ctrl.rgb ? clamp_byte(acc[1]) : '0;
		res_d.out_b      = ctrl.rgb ? clamp_byte(acc[2]) : '0;
		res_d.frame_last = ctrl.last;
	end

	assign in_ready = !v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= res_d;
		end
	end

	assign out_valid = v_q;
	assign result    = res_q;

endmodule

/* rtl/conv3x3_clamp_filter.sv */
// Top level of the streaming 3x3 convolution filter with per-channel clamping.
//
//   channel  valid         stall         payload      transaction
//   -------  ------------  ------------  -----------  -------------------------------
//   pixel    pixel_valid   pixel_stall   pixel_data   one raster pixel or drain item
//   result   result_valid  result_stall  result_data  one filtered, clamped pixel
//   config   cfg_we        (none)        cfg_data     register cfg_index, no read-back
//
// One pixel transaction per clock, sustained while result_stall is low. The
// line store is one memory with one write and one registered read per cycle;
// the read runs one transaction ahead, so its taps are ready when the next
// transaction is accepted. The window, product and sum registers lie in that
// order between the transaction that completes a window and the output; the
// stream itself runs W+1 transactions behind.
// Reset clears counters and pipeline valids and returns the configuration to
// its defaults; the line store is not cleared, its stale entries only ever
// fall on taps outside the image.
// A stalled result backs up through the stages; pixel_stall rises only when
// the window stage is full and cannot move on.
`timescale 1ns / 1ps

module conv3x3_clamp_filter #(
	parameter int MAX_WIDTH      = 1024,
	parameter int MAX_HEIGHT     = 1024,
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  c3cf_pkg::in_item_t               pixel_data,
	output logic                             result_valid,
	input  logic                             result_stall,
	output c3cf_pkg::out_item_t              result_data,
	input  logic                             cfg_we,
	input  logic [c3cf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [c3cf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import c3cf_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HAW = $clog2(MAX_HEIGHT);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int FW  = $clog2(MAX_WIDTH + 2);
	localparam int TW  = PROD_W - COEF_FRAC_BITS;
	localparam logic [WW-1:0] W_RESET = WW'((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET);
	localparam logic [HW-1:0] H_RESET = HW'((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET);

	// configuration
	krow_t [2:0]              kernel_q;
	logic signed [BIAS_W-1:0] bias_q;
	logic                     rgb_q;
	logic [WW-1:0]            w_eff_q;
	logic [HW-1:0]            h_eff_q;
	logic [31:0]              dim_raw;
	logic [31:0]              w_new;
	logic [31:0]              h_new;
	logic                     restart_cfg;

	// position in the frame
	logic [AW-1:0]  col_q;
	logic [HAW-1:0] row_q;
	logic [FW-1:0]  fill_q;
	logic [WW-1:0]  w_m1;
	logic [HW-1:0]  h_m1;
	logic           primed;
	logic           col_end;
	logic           row_end;
	logic           last_now;
	logic           accept;
	logic           restart_buf;

	// window stage
	window_t    win_q;
	logic       v1_q;
	edge_mask_t mask_s1;
	pix_ctrl_t  ctrl_s1;
	logic       s1_ready;
	pixel_t     new_px;
	pixel_t     tap_mid;
	pixel_t     tap_top;

	// later stages
	logic                    prod_ready;
	logic                    prod_valid;
	logic                    sum_ready;
	logic [2:0][8:0][TW-1:0] prod;
	pix_ctrl_t               ctrl_s2;

	// clip geometry writes: zero acts as one, oversize acts as the maximum
	always_comb begin
		dim_raw = 32'(cfg_data[DIM_CFG_W-1:0]);
		if (dim_raw == '0) begin
			w_new = 32'd1;
			h_new = 32'd1;
		end else begin
			w_new = (dim_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : dim_raw;
			h_new = (dim_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : dim_raw;
		end
	end

	// a mode or geometry write abandons the frame in progress
	assign restart_cfg = cfg_we && (cfg_index == REG_COLOR_MODE ||
		cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= {{KROW_W{1'b0}}, KERNEL_MID_RESET, {KROW_W{1'b0}}};
			bias_q   <= '0;
			rgb_q    <= 1'b0;
			w_eff_q  <= W_RESET;
			h_eff_q  <= H_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KERNEL_TOP:    kernel_q[0] <= cfg_data[KROW_W-1:0];
				REG_KERNEL_MID:    kernel_q[1] <= cfg_data[KROW_W-1:0];
				REG_KERNEL_BOTTOM: kernel_q[2] <= cfg_data[KROW_W-1:0];
				REG_BIAS:          bias_q      <= cfg_data[BIAS_W-1:0];
				REG_COLOR_MODE:    rgb_q       <= cfg_data[0];
				REG_IMAGE_WIDTH:   w_eff_q     <= w_new[WW-1:0];
				REG_IMAGE_HEIGHT:  h_eff_q     <= h_new[HW-1:0];
				default: begin
				end
			endcase
		end
	end

	// accept while the window stage is empty or moving on
	assign s1_ready    = !v1_q || prod_ready;
	assign pixel_stall = !s1_ready;
	assign accept      = pixel_valid && s1_ready;

	assign w_m1     = w_eff_q - 1'b1;
	assign h_m1     = h_eff_q - 1'b1;
	assign primed   = fill_q == (FW'(w_eff_q) + 1'b1);
	assign col_end  = col_q == w_m1[AW-1:0];
	assign row_end  = row_q == h_m1[HAW-1:0];
	assign last_now = col_end && row_end;
	assign restart_buf = restart_cfg || (accept && primed && last_now);

	// drain items enter as zero; gray mode keeps only the first channel
	always_comb begin
		new_px = '0;
		if (!pixel_data.pad_item) begin
			new_px[SAMPLE_W-1:0] = pixel_data.sample_r;
			if (rgb_q) begin
				new_px[2*SAMPLE_W-1:SAMPLE_W] = pixel_data.sample_g;
				new_px[PIX_W-1:2*SAMPLE_W]    = pixel_data.sample_b;
			end
		end
	end

	c3cf_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.restart (restart_buf),
		.sample  (new_px),
		.width   (w_eff_q),
		.tap_mid (tap_mid),
		.tap_top (tap_top)
	);

	// counters track the pixel at the window centre; hold until the window fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else if (restart_cfg) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (!primed) begin
				fill_q <= fill_q + 1'b1;
			end else if (last_now) begin
				col_q  <= '0;
				row_q  <= '0;
				fill_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (s1_ready) begin
			v1_q <= accept && primed;
		end
	end

	// advance the window by one column: newest on the right
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int ky = 0; ky < 3; ky++) begin
				win_q[ky][0] <= win_q[ky][1];
				win_q[ky][1] <= win_q[ky][2];
			end
			win_q[0][2] <= tap_top;
			win_q[1][2] <= tap_mid;
			win_q[2][2] <= new_px;
			mask_s1 <= '{left: col_q != '0, right: !col_end, top: row_q != '0,
				bottom: !row_end};
			ctrl_s1 <= '{rgb: rgb_q, last: last_now};
		end
	end

	c3cf_product_stage #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1_q),
		.in_ready  (prod_ready),
		.win       (win_q),
		.mask      (mask_s1),
		.ctrl      (ctrl_s1),
		.kernel    (kernel_q),
		.out_valid (prod_valid),
		.out_ready (sum_ready),
		.prod      (prod),
		.ctrl_out  (ctrl_s2)
	);

	c3cf_sum_stage #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (sum_ready),
		.prod      (prod),
		.ctrl      (ctrl_s2),
		.bias      (bias_q),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.result    (result_data)
	);

endmodule

/* sim/conv3x3_clamp_filter_test.sv */
// Self-checking testbench for the streaming 3x3 convolution filter with clamping.
`timescale 1ns / 1ps

module conv3x3_clamp_filter_test;

	import c3cf_pkg::*;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int COEF_FRAC_BITS = 12;
	// Ring of recent samples: two full lines plus the window corners.
	localparam int RING_DEPTH     = 2 * MAX_WIDTH + 4;
	// Cycles that a transaction with no result may still spend inside the pipeline.
	localparam int PIPE_SETTLE    = 8;
	localparam int RANDOM_ITEMS   = 1800;
	// One pixel wide, every row of the largest height, then two drain transactions.
	localparam int TALL_ITEMS     = MAX_HEIGHT + 2;
	localparam int SMALL_ITEMS    = RANDOM_ITEMS - TALL_ITEMS;
	localparam int CYCLE_LIMIT    = 400_000;
	// Register index that decodes to nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic {
		STEP_PIXEL,
		STEP_REG
	} step_kind_t;

	// One line of the directed script: a register write or a pixel transaction,
	// optionally with its result typed in by hand.
	typedef struct packed {
		step_kind_t kind;
		logic [CFG_INDEX_W-1:0] index;
		krow_t value;
		in_item_t px;
		logic typed;
		out_item_t want;
	} script_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	in_item_t pixel_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result_data;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	conv3x3_clamp_filter #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_data(pixel_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the block: configuration, sample ring and output position.
	krow_t k_top, k_mid, k_bot;
	logic [BIAS_W-1:0] bias_q;
	logic rgb_q;
	logic [DIM_CFG_W-1:0] width_q, height_q;
	pixel_t ring [RING_DEPTH];
	int wr_pos;
	int col_pos, row_pos;
	int taken;   // transactions of this frame, saturating at W+2

	out_item_t filtered_due [$];
	out_item_t due;
	script_row_t script [$];

	int unsigned send_idle_pct = 27;
	int unsigned recv_stall_pct = 68;
	int unsigned pixels_sent = 0;
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Out-of-range geometry: zero acts as one, anything above the maximum as the maximum.
	function automatic int unsigned eff_dim(logic [DIM_CFG_W-1:0] v, int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Product of a sample and a Q4.12 coefficient, truncated toward zero before summing.
	function automatic int scaled_product(int level, logic signed [COEF_W-1:0] coef);
		int p;
		p = level * coef;
		return (p < 0) ? -((-p) >> COEF_FRAC_BITS) : (p >> COEF_FRAC_BITS);
	endfunction

	function automatic logic [SAMPLE_W-1:0] clamp_level(int v);
		if (v < 0) return '0;
		if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
		return SAMPLE_W'(v);
	endfunction

	function automatic void rewind_frame();
		col_pos = 0;
		row_pos = 0;
		taken = 0;
	endfunction

	// Geometry and mode writes abort the frame in flight; kernel and bias do not.
	function automatic void load_reg(logic [CFG_INDEX_W-1:0] idx, krow_t val);
		case (idx)
			REG_KERNEL_TOP:    k_top = val;
			REG_KERNEL_MID:    k_mid = val;
			REG_KERNEL_BOTTOM: k_bot = val;
			REG_BIAS:          bias_q = val[BIAS_W-1:0];
			REG_COLOR_MODE: begin
				rgb_q = val[0];
				rewind_frame();
			end
			REG_IMAGE_WIDTH: begin
				width_q = val[DIM_CFG_W-1:0];
				rewind_frame();
			end
			REG_IMAGE_HEIGHT: begin
				height_q = val[DIM_CFG_W-1:0];
				rewind_frame();
			end
			default: ;
		endcase
	endfunction

	// Take one pixel transaction; return 1 with the filtered pixel it releases, if any.
	function automatic bit convolve_pixel(input in_item_t it, output out_item_t res);
		int w, h, r, c, back, b;
		int acc [3];
		pixel_t pix_in, tap;
		krow_t krow;
		logic signed [COEF_W-1:0] coef;
		bit last;
		w = eff_dim(width_q, MAX_WIDTH);
		h = eff_dim(height_q, MAX_HEIGHT);
		res = '0;
		pix_in = '0;
		if (!it.pad_item) begin
			pix_in[7:0] = it.sample_r;
			if (rgb_q) begin
				pix_in[15:8]  = it.sample_g;
				pix_in[23:16] = it.sample_b;
			end
		end
		wr_pos = (wr_pos + 1) % RING_DEPTH;
		ring[wr_pos] = pix_in;
		if (taken < w + 2) taken++;
		if (taken < w + 2) return 0;

		acc[0] = 0;
		acc[1] = 0;
		acc[2] = 0;
		for (int dy = -1; dy <= 1; dy++) begin
			krow = (dy < 0) ? k_top : ((dy == 0) ? k_mid : k_bot);
			r = row_pos + dy;
			if (r < 0 || r >= h) continue;
			for (int dx = -1; dx <= 1; dx++) begin
				c = col_pos + dx;
				if (c < 0 || c >= w) continue;
				// The output runs W+1 transactions behind the newest sample.
				back = w + 1 - dy * w - dx;
				tap = ring[(wr_pos + RING_DEPTH - back) % RING_DEPTH];
				coef = krow[COEF_W*(dx+1) +: COEF_W];
				for (int ch = 0; ch < 3; ch++)
					acc[ch] += scaled_product(int'(tap[SAMPLE_W*ch +: SAMPLE_W]), coef);
			end
		end

		b = int'($signed(bias_q));
		last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
		res.out_r = clamp_level(acc[0] + b);
		res.out_g = rgb_q ? clamp_level(acc[1] + b) : '0;
		res.out_b = rgb_q ? clamp_level(acc[2] + b) : '0;
		res.frame_last = last;

		if (last) begin
			rewind_frame();
		end else if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos++;
		end
		return 1;
	endfunction

	function automatic krow_t rand_krow();
		krow_t k;
		// Mostly modest coefficients so that sums land inside the clamp range.
		for (int i = 0; i < 3; i++)
			k[COEF_W*i +: COEF_W] = ($urandom_range(3) == 0) ? COEF_W'($urandom)
				: COEF_W'($urandom_range(12288) - 6144);
		return k;
	endfunction

	function automatic script_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, krow_t val);
		return '{STEP_REG, idx, val, '0, 1'b0, '0};
	endfunction

	function automatic script_row_t pix_row(logic pad, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		return '{STEP_PIXEL, '0, '0, '{pad, r, g, b}, 1'b0, '0};
	endfunction

	// Gray-mode pixel whose result is known by inspection.
	function automatic script_row_t chk_row(logic pad, logic [7:0] r, logic [7:0] want_r,
			logic last);
		return '{STEP_PIXEL, '0, '0, '{pad, r, 8'h5A, 8'hA5}, 1'b1,
			'{want_r, 8'h00, 8'h00, last}};
	endfunction

	// Hold valid low until every due result has come back.
	task automatic wait_results_drained();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (filtered_due.size() != 0) @(negedge clk);
	endtask

	// Write only with the pipeline empty; let transactions with no result settle first.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input krow_t val);
		wait_results_drained();
		repeat (PIPE_SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		load_reg(idx, val);
	endtask

	task automatic push_pixel(input in_item_t item, input logic typed,
			input out_item_t typed_res);
		out_item_t res;
		bit produced;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_data  <= item;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		produced = convolve_pixel(item, res);
		if (typed)
			filtered_due.push_back(typed_res);
		else if (produced)
			filtered_due.push_back(res);
		pixels_sent++;
	endtask

	// One frame of W*H pixels and W+1 drain transactions; a broken frame stops
	// part way and is aborted by a geometry write.
	task automatic stream_frame(input bit broken);
		int unsigned w, h, span, cut;
		in_item_t px;
		w = eff_dim(width_q, MAX_WIDTH);
		h = eff_dim(height_q, MAX_HEIGHT);
		span = w * h + w + 1;
		cut = broken ? $urandom_range(span - 1, 1) : span;
		for (int unsigned i = 0; i < cut; i++) begin
			px.sample_r = 8'($urandom);
			px.sample_g = 8'($urandom);
			px.sample_b = 8'($urandom);
			// Pads inside the frame are rare; stray pixels in the drain likewise.
			if (i < w * h)
				px.pad_item = ($urandom_range(15) == 0);
			else
				px.pad_item = ($urandom_range(7) != 0);
			push_pixel(px, 1'b0, '0);
			if ($urandom_range(199) == 0) wait_results_drained();
		end
		if (broken) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width_q));
	endtask

	// Receiver: stall at random according to the current idling mode.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Compare every result transaction with the oldest one due.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (filtered_due.size() == 0) begin
				$error("unexpected result: %p", result_data);
				fault_count++;
			end else begin
				due = filtered_due.pop_front();
				if (result_data.out_r !== due.out_r) begin
					$error("out_r: expected %0d, got %0d", due.out_r, result_data.out_r);
					fault_count++;
				end
				if (result_data.out_g !== due.out_g) begin
					$error("out_g: expected %0d, got %0d", due.out_g, result_data.out_g);
					fault_count++;
				end
				if (result_data.out_b !== due.out_b) begin
					$error("out_b: expected %0d, got %0d", due.out_b, result_data.out_b);
					fault_count++;
				end
				if (result_data.frame_last !== due.frame_last) begin
					$error("frame_last: expected %0d, got %0d", due.frame_last,
						result_data.frame_last);
					fault_count++;
				end
			end
		end
	end

	// Watchdog: drop the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned random_done, mark, frames, wdim, hdim;
		bit big;
		bit tall_done;
		logic [BIAS_W-1:0] bias_pick;

		// Mirror the reset state of the block.
		k_top = '0;
		k_mid = KERNEL_MID_RESET;
		k_bot = '0;
		bias_q = '0;
		rgb_q = 1'b0;
		width_q = DIM_CFG_W'(DIM_RESET);
		height_q = DIM_CFG_W'(DIM_RESET);
		for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
		wr_pos = 0;
		rewind_frame();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Identity kernel from reset on a 2x2 gray frame: extremes, a pad inside
		// the frame, and a stray pixel in the drain.
		script.push_back(reg_row(REG_IMAGE_WIDTH, 48'd2));
		script.push_back(reg_row(REG_IMAGE_HEIGHT, 48'd2));
		script.push_back(pix_row(1'b0, 8'h00, 8'h5A, 8'hA5));
		script.push_back(pix_row(1'b0, 8'hFF, 8'h12, 8'h34));
		script.push_back(pix_row(1'b1, 8'h80, 8'h80, 8'h80));
		script.push_back(chk_row(1'b0, 8'h7F, 8'h00, 1'b0));
		script.push_back(chk_row(1'b1, 8'h00, 8'hFF, 1'b0));
		script.push_back(chk_row(1'b0, 8'hC3, 8'h00, 1'b0));
		script.push_back(chk_row(1'b1, 8'h00, 8'h7F, 1'b1));
		// Bias at both ends on a single-pixel frame: clamp high, then low.
		script.push_back(reg_row(REG_BIAS, 48'h1FF));
		script.push_back(reg_row(REG_IMAGE_WIDTH, 48'd1));
		script.push_back(reg_row(REG_IMAGE_HEIGHT, 48'd1));
		script.push_back(pix_row(1'b0, 8'h00, 8'h00, 8'h00));
		script.push_back(pix_row(1'b1, 8'h00, 8'h00, 8'h00));
		script.push_back(chk_row(1'b1, 8'h00, 8'hFF, 1'b1));
		script.push_back(reg_row(REG_BIAS, 48'h200));
		script.push_back(pix_row(1'b0, 8'hFF, 8'hFF, 8'hFF));
		script.push_back(pix_row(1'b1, 8'h00, 8'h00, 8'h00));
		script.push_back(chk_row(1'b1, 8'h00, 8'h00, 1'b1));
		// Sharpening kernel in RGB mode.
		script.push_back(reg_row(REG_COLOR_MODE, 48'd1));
		script.push_back(reg_row(REG_BIAS, 48'h000));
		script.push_back(reg_row(REG_KERNEL_TOP, 48'h0000_F000_0000));
		script.push_back(reg_row(REG_KERNEL_MID, 48'hF000_5000_F000));
		script.push_back(reg_row(REG_KERNEL_BOTTOM, 48'h0000_F000_0000));
		script.push_back(reg_row(REG_IMAGE_WIDTH, 48'd2));
		script.push_back(pix_row(1'b0, 8'h10, 8'h80, 8'hFF));
		script.push_back(pix_row(1'b0, 8'h20, 8'h40, 8'h00));
		script.push_back(pix_row(1'b1, 8'h00, 8'h00, 8'h00));
		script.push_back(pix_row(1'b1, 8'h00, 8'h00, 8'h00));
		script.push_back(pix_row(1'b1, 8'h00, 8'h00, 8'h00));
		// Most negative and most positive coefficients on a 1x2 column.
		script.push_back(reg_row(REG_KERNEL_TOP, 48'h8000_8000_8000));
		script.push_back(reg_row(REG_KERNEL_MID, 48'h7FFF_7FFF_7FFF));
		script.push_back(reg_row(REG_KERNEL_BOTTOM, 48'h7FFF_8000_7FFF));
		script.push_back(reg_row(REG_BIAS, 48'h1FF));
		script.push_back(reg_row(REG_IMAGE_WIDTH, 48'd1));
		script.push_back(reg_row(REG_IMAGE_HEIGHT, 48'd2));
		script.push_back(pix_row(1'b0, 8'hFF, 8'hFF, 8'hFF));
		script.push_back(pix_row(1'b0, 8'h01, 8'h80, 8'hFF));
		script.push_back(pix_row(1'b1, 8'h00, 8'h00, 8'h00));
		script.push_back(pix_row(1'b1, 8'h00, 8'h00, 8'h00));
		// Abort a frame part way, then hit an index that decodes to nothing.
		script.push_back(reg_row(REG_IMAGE_WIDTH, 48'd3));
		script.push_back(reg_row(REG_IMAGE_HEIGHT, 48'd3));
		script.push_back(pix_row(1'b0, 8'hAA, 8'h55, 8'h0F));
		script.push_back(pix_row(1'b0, 8'h55, 8'hAA, 8'hF0));
		script.push_back(reg_row(REG_IMAGE_HEIGHT, 48'd3));
		script.push_back(reg_row(REG_UNUSED, 48'hFFFF_FFFF_FFFF));

		foreach (script[i]) begin
			if (script[i].kind == STEP_REG)
				write_reg(script[i].index, script[i].value);
			else
				push_pixel(script[i].px, script[i].typed, script[i].want);
		end

		// Random phases: fresh settings, then a few frames. Once the last idling
		// mode starts, one phase carries a single frame of zero width (one pixel)
		// and an oversize height (the largest).
		random_done = 0;
		tall_done = 1'b0;
		while (random_done < RANDOM_ITEMS) begin
			if (random_done < SMALL_ITEMS / 3) begin
				send_idle_pct = 27;
				recv_stall_pct = 68;
			end else if (random_done < 2 * SMALL_ITEMS / 3) begin
				send_idle_pct = 68;
				recv_stall_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			big = !tall_done && (random_done >= 2 * SMALL_ITEMS / 3);

			write_reg(REG_KERNEL_TOP, rand_krow());
			write_reg(REG_KERNEL_MID, rand_krow());
			write_reg(REG_KERNEL_BOTTOM, rand_krow());
			bias_pick = ($urandom_range(3) == 0) ? BIAS_W'($urandom)
				: BIAS_W'($urandom_range(64) - 32);
			write_reg(REG_BIAS, CFG_DATA_W'(bias_pick));
			write_reg(REG_COLOR_MODE, CFG_DATA_W'($urandom_range(1)));

			if (big) begin
				wdim = 0;
				hdim = 2047;
				tall_done = 1'b1;
			end else begin
				wdim = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
				hdim = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
			end
			write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wdim));
			write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hdim));
			if ($urandom_range(7) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));

			mark = pixels_sent;
			frames = big ? 1 : $urandom_range(4, 1);
			repeat (frames) stream_frame(!big && ($urandom_range(9) == 0));
			random_done += pixels_sent - mark;
		end

		// Drain, then give the pipeline time to show any surplus result.
		wait_results_drained();
		repeat (4 * PIPE_SETTLE) @(posedge clk);
		if (fault_count == 0 && filtered_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
rtl/c3cf_pkg.sv
rtl/c3cf_line_buf.sv
rtl/c3cf_product_stage.sv
rtl/c3cf_sum_stage.sv
rtl/conv3x3_clamp_filter.sv
sim/conv3x3_clamp_filter_test.sv
